// File: sv/rma_pkg.sv
// Package for the ring moving-average block: window and sample sizes,
// derived widths and the sequencer state type. No dependencies.
package rma_pkg;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 16;

    // Widths that follow from the window depth and the sample width
    localparam int SLOT_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_BITS   = $clog2(WINDOW + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int DIV_CNT_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

    localparam logic [COUNT_BITS-1:0]   WINDOW_COUNT = COUNT_BITS'(WINDOW);
    localparam logic [SLOT_BITS-1:0]    LAST_SLOT    = SLOT_BITS'(WINDOW - 1);
    localparam logic [DIV_CNT_BITS-1:0] DIV_FIRST    = DIV_CNT_BITS'(SUM_BITS - 1);

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } rma_state_t;

endpackage

// File: sv/ring_moving_average.sv
// Ring moving-average block: sample ring, running sum and a bit-serial divider.
// Depends on rma_pkg for sizes, widths and the sequencer state type.
//
// Usage:
//   Input channel (s_valid/s_ready): one word carries s_func and s_sample.
//   s_func = push stores s_sample in a ring of WINDOW entries and updates the
//   running sum; s_func = clear empties the window at once (the ring itself is
//   left untouched, since an entry is only used once the window is full).
//   Result channel (m_valid/m_ready): one word per input word with m_average
//   (sum / fill level, truncated toward zero), m_fill_level and m_window_full.
//   A push passes through ST_READ (oldest ring entry at hand), ST_UPDATE (sum
//   and ring), ST_DIV (restoring division, SUM_BITS (20) quotient bits) and
//   ST_DONE, which loads the output register; s_ready is high again in the
//   same cycle that the result becomes valid. No new word is taken before then.
//   The division uses a single divider step, one quotient bit a cycle.
//   A clear skips the read, update and division and goes straight to ST_DONE.
//   The output register parts the two sides: a new word is accepted while the
//   previous result still waits. If the receiver stalls, the finished result
//   is held in the sequencer until the output register is free.
//   Reset (aresetn low, synchronous) empties the window and drops any
//   pending result; ring contents need no clearing.
module ring_moving_average (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic signed [rma_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rma_pkg::SAMPLE_BITS-1:0] m_average,
    output logic [rma_pkg::COUNT_BITS-1:0]        m_fill_level,
    output logic                                  m_window_full
);

    localparam int SB  = rma_pkg::SAMPLE_BITS;
    localparam int CB  = rma_pkg::COUNT_BITS;
    localparam int SLB = rma_pkg::SLOT_BITS;
    localparam int SUB = rma_pkg::SUM_BITS;
    localparam int DCB = rma_pkg::DIV_CNT_BITS;

    // Sample ring: written once per push, read at the write slot before that
    logic signed [SB-1:0] ring_mem [rma_pkg::WINDOW];
    logic signed [SB-1:0] ring_rd_reg;

    rma_pkg::rma_state_t state_reg, state_next;

    logic [SLB-1:0]        slot_reg, slot_next;
    logic [CB-1:0]         count_reg, count_next;
    logic signed [SUB-1:0] sum_reg, sum_next;
    logic signed [SB-1:0]  sample_reg, sample_next;

    // Divider: quo_reg starts as the dividend magnitude and ends as quotient
    logic [SUB-1:0] quo_reg, quo_next;
    logic [CB-1:0]  rem_reg, rem_next;
    logic [DCB-1:0] bit_cnt_reg, bit_cnt_next;
    logic           neg_reg, neg_next;

    logic                 m_valid_reg, m_valid_next;
    logic signed [SB-1:0] m_average_reg, m_average_next;
    logic [CB-1:0]        m_fill_reg, m_fill_next;
    logic                 m_full_reg, m_full_next;

    logic                  in_fire;
    logic                  out_free;
    logic signed [SUB-1:0] new_sum;
    logic [SUB-1:0]        new_mag;
    logic [CB:0]           trial;
    logic [CB:0]           trial_diff;
    logic                  trial_ge;
    logic [SUB-1:0]        signed_quo;

    assign s_ready  = (state_reg == rma_pkg::ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Running sum: add the new sample, drop the oldest once the window is full
    always_comb begin
        new_sum = sum_reg + SUB'(sample_reg);
        if (count_reg == rma_pkg::WINDOW_COUNT) begin
            new_sum = new_sum - SUB'(ring_rd_reg);
        end
        new_mag = new_sum[SUB-1] ? (~new_sum + SUB'(1)) : new_sum;
    end

    // One restoring-division step: bring in the next dividend bit
    assign trial      = {rem_reg, quo_reg[SUB-1]};
    assign trial_diff = trial - {1'b0, count_reg};
    assign trial_ge   = (trial >= {1'b0, count_reg});
    assign signed_quo = neg_reg ? (~quo_reg + SUB'(1)) : quo_reg;

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        neg_next       = neg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_average_next = m_average_reg;
        m_fill_next    = m_fill_reg;
        m_full_next    = m_full_reg;

        unique case (state_reg)
            rma_pkg::ST_IDLE: begin
                if (in_fire) begin
                    sample_next = s_sample;
                    if (s_func == rma_pkg::FUNC_CLEAR) begin
                        slot_next  = '0;
                        count_next = '0;
                        sum_next   = '0;
                        quo_next   = '0;
                        neg_next   = 1'b0;
                        state_next = rma_pkg::ST_DONE;
                    end else begin
                        state_next = rma_pkg::ST_READ;
                    end
                end
            end
            rma_pkg::ST_READ: begin
                // Oldest entry arrives in ring_rd_reg this cycle
                state_next = rma_pkg::ST_UPDATE;
            end
            rma_pkg::ST_UPDATE: begin
                sum_next = new_sum;
                if (count_reg != rma_pkg::WINDOW_COUNT) begin
                    count_next = count_reg + CB'(1);
                end
                slot_next    = (slot_reg == rma_pkg::LAST_SLOT) ? '0 : slot_reg + SLB'(1);
                quo_next     = new_mag;
                neg_next     = new_sum[SUB-1];
                rem_next     = '0;
                bit_cnt_next = rma_pkg::DIV_FIRST;
                state_next   = rma_pkg::ST_DIV;
            end
            rma_pkg::ST_DIV: begin
                rem_next = trial_ge ? trial_diff[CB-1:0] : trial[CB-1:0];
                quo_next = {quo_reg[SUB-2:0], trial_ge};
                if (bit_cnt_reg == '0) begin
                    state_next = rma_pkg::ST_DONE;
                end else begin
                    bit_cnt_next = bit_cnt_reg - DCB'(1);
                end
            end
            rma_pkg::ST_DONE: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_average_next = signed_quo[SB-1:0];
                    m_fill_next    = count_reg;
                    m_full_next    = (count_reg == rma_pkg::WINDOW_COUNT);
                    state_next     = rma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rma_pkg::ST_IDLE;
            slot_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg    <= sample_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        neg_reg       <= neg_next;
        m_average_reg <= m_average_next;
        m_fill_reg    <= m_fill_next;
        m_full_reg    <= m_full_next;
    end

    // Ring write: store the sample in the current slot during the update
    always_ff @(posedge aclk) begin
        if (state_reg == rma_pkg::ST_UPDATE) begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    // Ring read: fetch the entry about to be overwritten
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ring_rd_reg <= ring_mem[slot_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = m_average_reg;
    assign m_fill_level  = m_fill_reg;
    assign m_window_full = m_full_reg;

    // Fill level never passes the window depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rma_pkg::WINDOW_COUNT)
        else $error("fill level beyond window depth");

    // Divisor is never zero while dividing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rma_pkg::ST_DIV) |-> (count_reg != '0))
        else $error("division by zero fill level");

    // A clear empties the window on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_func == rma_pkg::FUNC_CLEAR) |=>
            (count_reg == '0 && sum_reg == '0 && slot_reg == '0))
        else $error("clear did not empty the window");

    // Full flag matches the reported fill level
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_full == (m_fill_level == rma_pkg::WINDOW_COUNT)))
        else $error("full flag disagrees with fill level");

    // A push starts the ring read sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_func == rma_pkg::FUNC_PUSH) |=> (state_reg == rma_pkg::ST_READ))
        else $error("push did not start the sequencer");

endmodule
